// File: design/adc_pkg.sv
// Shared constants, types and functions of the AD-Census cost block.
`default_nettype none
package adc_pkg;
    localparam int MaxDisp = 64;
    // twice the disparity range, so columns queued ahead of the back end never
    // overwrite entries the current sweep still reads
    localparam int HistDepth = 2 * MaxDisp;
    localparam int HistAw = $clog2(HistDepth);
    localparam int CntW = $clog2(MaxDisp + 1);
    localparam int OneQ15 = 32768;
    // pipelined divider stages, two quotient bits each
    localparam int DivStages = 4;

    localparam logic [1:0] RegMinDisp = 2'd0;
    localparam logic [1:0] RegMaxDisp = 2'd1;
    localparam logic [1:0] RegLambdaC = 2'd2;
    localparam logic [1:0] RegLambdaH = 2'd3;

    // Per-pixel job handed from front to back.
    typedef struct packed {
        logic [7:0]        lb;
        logic [7:0]        lg;
        logic [7:0]        lr;
        logic [63:0]       code;
        logic [HistAw-1:0] wp;
        logic [CntW-1:0]   col;
        logic [6:0]        lo;
        logic [6:0]        hi;
    } job_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
        logic [63:0] code;
    } hist_t;

    // 1 - exp(-i/32) in Q.15 for i = 0..255; entry i sits in bits [16i+15:16i].
    function automatic logic [4095:0] exp_table();
        logic [63:0]   e;
        logic [63:0]   ex;
        logic [4095:0] tab;
        e = 64'd1 << 30;
        tab = '0;
        for (int i = 0; i < 256; i++) begin
            ex = (e + (64'd1 << 14)) >> 15;
            tab[i*16 +: 16] = (ex > 64'd32768) ? 16'd0 : 16'(64'd32768 - ex);
            e = (e * 64'd1040706261 + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

    localparam logic [4095:0] ExpTab = exp_table();
endpackage
`default_nettype wire

// File: design/adc_front.sv
// Front end: accepts columns, keeps column count, writes right history, queues jobs.
`default_nettype none
module adc_front
    import adc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  left_blue,
    input  wire logic [7:0]  left_green,
    input  wire logic [7:0]  left_red,
    input  wire logic [7:0]  right_blue,
    input  wire logic [7:0]  right_green,
    input  wire logic [7:0]  right_red,
    input  wire logic [63:0] left_code,
    input  wire logic [63:0] right_code,
    input  wire logic        row_start,
    input  wire logic [5:0]  min_disp,
    input  wire logic [6:0]  max_disp,
    output logic             hist_we,
    output logic [HistAw-1:0] hist_wa,
    output hist_t            hist_wd,
    output logic             job_valid,
    input  wire logic        job_ready,
    output job_t             job
);
    logic [HistAw-1:0] wp_reg;
    logic [CntW-1:0]   col_reg;
    // two-entry queue
    job_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       acc;
    logic [CntW-1:0] x;
    logic [HistAw-1:0] wp_next;
    logic [6:0] hi;

    assign in_ready = (cnt_reg != 2'd2);
    assign acc = in_valid && in_ready;
    assign x = row_start ? '0 : col_reg;
    assign wp_next = wp_reg + 1'b1;
    assign hi = (max_disp > 7'(MaxDisp)) ? 7'(MaxDisp) : max_disp;
    assign hist_we = acc;
    assign hist_wa = wp_next;
    assign hist_wd = '{b: right_blue, g: right_green, r: right_red, code: right_code};
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            col_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                wp_reg <= wp_next;
                col_reg <= (x < CntW'(MaxDisp - 1)) ? x + 1'b1 : x;
                wr_reg <= ~wr_reg;
            end
            if (job_valid && job_ready)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, acc} - {1'b0, job_valid && job_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            q_reg[wr_reg] <= '{lb: left_blue, lg: left_green, lr: left_red,
                code: left_code, wp: wp_next, col: x, lo: {1'b0, min_disp}, hi: hi};
    end
endmodule
`default_nettype wire

// File: design/adc_back.sv
// Back end: sweeps disparities, reads history, computes cost in a short pipeline.
`default_nettype none
module adc_back
    import adc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    output logic             job_ready,
    input  job_t             job,
    input  wire logic        hist_we,
    input  wire logic [HistAw-1:0] hist_wa,
    input  hist_t            hist_wd,
    input  wire logic [7:0]  lambda_c,
    input  wire logic [7:0]  lambda_h,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [16:0]      match_cost,
    output logic [5:0]       disparity,
    output logic             last
);
    hist_t mem [HistDepth];

    logic       busy_reg;
    job_t       cur_reg;
    logic [6:0] d_reg;

    // stage 1: memory read issued
    logic       s1_v_reg, s1_off_reg, s1_last_reg;
    logic [5:0] s1_d_reg;
    hist_t      s1_h_reg;
    // stage 2: sad/ham
    logic       s2_v_reg, s2_off_reg, s2_last_reg;
    logic [5:0] s2_d_reg;
    logic [9:0] s2_sad_reg;
    logic [6:0] s2_ham_reg;
    // divider stages: {quotient, remainder}, quotient bit 8 marks saturation
    logic        dv_v_reg [DivStages+1];
    logic        dv_off_reg [DivStages+1];
    logic        dv_last_reg [DivStages+1];
    logic [5:0]  dv_d_reg [DivStages+1];
    logic [23:0] dv_a_reg [DivStages+1];
    logic [23:0] dv_c_reg [DivStages+1];
    // output
    logic       o_v_reg;

    logic [7:0] lc, lh;
    logic       adv, issue;
    logic [7:0] db, dg, dr;
    logic [6:0] ham;
    logic [63:0] xr;
    logic [14:0] sad32;
    logic [9:0]  lc3;
    logic [11:0] ham32;
    logic        sat_a, sat_c;
    logic [15:0] ta, tc;

    assign lc = (lambda_c == 8'd0) ? 8'd1 : lambda_c;
    assign lh = (lambda_h == 8'd0) ? 8'd1 : lambda_h;
    // pipeline moves when the output slot is free or being drained
    assign adv = !o_v_reg || out_ready;
    assign issue = busy_reg && adv;
    // load the next job only on a moving edge, so the item still in stage 1
    // sees the left pixel of its own job
    assign job_ready = !busy_reg && adv;

    always_ff @(posedge clk)
    begin
        if (hist_we)
            mem[hist_wa] <= hist_wd;
        if (adv)
            s1_h_reg <= mem[HistAw'(cur_reg.wp - d_reg[HistAw-1:0])];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            d_reg <= '0;
        end
        else if (!busy_reg)
        begin
            if (job_valid && job_ready && job.lo < job.hi)
            begin
                busy_reg <= 1'b1;
                d_reg <= job.lo;
            end
        end
        else if (issue)
        begin
            d_reg <= d_reg + 1'b1;
            if (d_reg + 1'b1 == cur_reg.hi)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
            cur_reg <= job;
    end

    always_comb
    begin
        db = (cur_reg.lb > s1_h_reg.b) ? cur_reg.lb - s1_h_reg.b : s1_h_reg.b - cur_reg.lb;
        dg = (cur_reg.lg > s1_h_reg.g) ? cur_reg.lg - s1_h_reg.g : s1_h_reg.g - cur_reg.lg;
        dr = (cur_reg.lr > s1_h_reg.r) ? cur_reg.lr - s1_h_reg.r : s1_h_reg.r - cur_reg.lr;
        xr = cur_reg.code ^ s1_h_reg.code;
        ham = '0;
        for (int i = 0; i < 64; i++)
            ham = ham + 7'(xr[i]);
        sad32 = {s2_sad_reg, 5'd0};
        lc3 = 10'(lc) * 10'd3;
        ham32 = {s2_ham_reg, 5'd0};
        // quotient of 256 or more saturates the term
        sat_a = {3'd0, sad32} >= {lc3, 8'd0};
        sat_c = {4'd0, ham32} >= {lh, 8'd0};
    end

    // One restoring division step: try quotient bit b.
    function automatic logic [23:0] div_bit(input logic [23:0] qr, input logic [9:0] den,
                                            input logic [2:0] b);
        logic [17:0] r;
        logic [17:0] t;
        logic [8:0]  q;
        q = qr[23:15];
        r = {3'd0, qr[14:0]};
        t = {8'd0, den} << b;
        if (r >= t)
        begin
            r = r - t;
            q = q | (9'd1 << b);
        end
        return {q, r[14:0]};
    endfunction

    assign ta = dv_a_reg[DivStages][23] ? 16'(OneQ15)
              : ExpTab[{dv_a_reg[DivStages][22:15], 4'd0} +: 16];
    assign tc = dv_c_reg[DivStages][23] ? 16'(OneQ15)
              : ExpTab[{dv_c_reg[DivStages][22:15], 4'd0} +: 16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            for (int k = 0; k <= DivStages; k++)
                dv_v_reg[k] <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            dv_v_reg[0] <= s2_v_reg;
            for (int k = 0; k < DivStages; k++)
                dv_v_reg[k+1] <= dv_v_reg[k];
            o_v_reg <= dv_v_reg[DivStages];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_off_reg <= d_reg > 7'(cur_reg.col);
            s1_last_reg <= (d_reg + 1'b1 == cur_reg.hi);
            s1_d_reg <= d_reg[5:0];
            s2_off_reg <= s1_off_reg;
            s2_last_reg <= s1_last_reg;
            s2_d_reg <= s1_d_reg;
            s2_sad_reg <= 10'(db) + 10'(dg) + 10'(dr);
            s2_ham_reg <= ham;
            dv_off_reg[0] <= s2_off_reg;
            dv_last_reg[0] <= s2_last_reg;
            dv_d_reg[0] <= s2_d_reg;
            dv_a_reg[0] <= {sat_a ? 9'd256 : 9'd0, sad32};
            dv_c_reg[0] <= {sat_c ? 9'd256 : 9'd0, {3'd0, ham32}};
            for (int k = 0; k < DivStages; k++)
            begin
                dv_off_reg[k+1] <= dv_off_reg[k];
                dv_last_reg[k+1] <= dv_last_reg[k];
                dv_d_reg[k+1] <= dv_d_reg[k];
                dv_a_reg[k+1] <= div_bit(div_bit(dv_a_reg[k], lc3, 3'(7 - 2 * k)),
                                         lc3, 3'(6 - 2 * k));
                dv_c_reg[k+1] <= div_bit(div_bit(dv_c_reg[k], {2'd0, lh}, 3'(7 - 2 * k)),
                                         {2'd0, lh}, 3'(6 - 2 * k));
            end
            match_cost <= dv_off_reg[DivStages] ? 17'(OneQ15) : 17'(ta) + 17'(tc);
            disparity <= dv_d_reg[DivStages];
            last <= dv_last_reg[DivStages];
        end
    end

    assign out_valid = o_v_reg;
endmodule
`default_nettype wire

// File: design/adc_cfg.sv
// Configuration register file.
`default_nettype none
module adc_cfg
    import adc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic [5:0]       min_disp,
    output logic [6:0]       max_disp,
    output logic [7:0]       lambda_c,
    output logic [7:0]       lambda_h
);
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_disp <= 6'd0;
            max_disp <= 7'd64;
            lambda_c <= 8'd10;
            lambda_h <= 8'd30;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                RegMinDisp: min_disp <= cfg_data[5:0];
                RegMaxDisp: max_disp <= cfg_data[6:0];
                RegLambdaC: lambda_c <= cfg_data;
                RegLambdaH: lambda_h <= cfg_data;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/ad_census_matching_cost.sv
// AD-Census stereo matching cost, top level.
// Usage:
//   s_axis: one column per transaction; tdata carries left B,G,R, right B,G,R,
//   left code, right code; tuser carries row_start.
//   m_axis: one cost per disparity from the start register up to the end register
//   (capped at 64) minus one; tdata = match_cost, disparity; tlast marks the final disparity.
//   cfg: index 0..3 = disparity start, disparity end, color lambda, Hamming lambda.
// The first cost of a column passes stage 1, stage 2, the divider stages and the output register.
// Throughput: one cost per cycle while m_axis_tready is high, set by the single history
//   read port in the back end; the back end issues no cost while it loads a job, and a
//   pixel with an empty range yields no cost; a two-entry job queue lets the front take
//   columns while the back sweeps.
// Reset clears column count, history pointer, queue and pipeline; registers
//   return to their defaults. History contents are undefined until written.
// When m_axis_tready is low the whole back pipeline holds; the queue fills
//   and s_axis_tready then drops.
`default_nettype none
module ad_census_matching_cost
    import adc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // left_blue, left_green, left_red, right_blue, right_green, right_red,
    // left_code, right_code
    input  wire logic [175:0] s_axis_tdata,
    input  wire logic         s_axis_tuser, // row_start
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata, // match_cost, disparity, pad
    output logic              m_axis_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);
    logic [5:0] min_disp;
    logic [6:0] max_disp;
    logic [7:0] lambda_c, lambda_h;
    logic hist_we, job_valid, job_ready;
    logic [HistAw-1:0] hist_wa;
    hist_t hist_wd;
    job_t job;
    logic [16:0] cost;
    logic [5:0] disp;

    adc_cfg u_cfg (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .min_disp, .max_disp, .lambda_c, .lambda_h);

    adc_front u_front (.clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .left_blue(s_axis_tdata[7:0]), .left_green(s_axis_tdata[15:8]),
        .left_red(s_axis_tdata[23:16]), .right_blue(s_axis_tdata[31:24]),
        .right_green(s_axis_tdata[39:32]), .right_red(s_axis_tdata[47:40]),
        .left_code(s_axis_tdata[111:48]), .right_code(s_axis_tdata[175:112]),
        .row_start(s_axis_tuser), .min_disp, .max_disp,
        .hist_we, .hist_wa, .hist_wd, .job_valid, .job_ready, .job);

    adc_back u_back (.clk, .rst_n, .job_valid, .job_ready, .job,
        .hist_we, .hist_wa, .hist_wd, .lambda_c, .lambda_h,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .match_cost(cost), .disparity(disp), .last(m_axis_tlast));

    assign m_axis_tdata = {1'b0, disp, cost};
endmodule
`default_nettype wire

// File: design/adc_checker.sv
// Port-level checks of the AD-Census cost block.
`default_nettype none
module adc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_cost_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
        else $error("cost out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable({m_axis_tlast, m_axis_tdata}))
        else $error("stalled output changed");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[23])
        else $error("pad bit set");
endmodule

bind ad_census_matching_cost adc_checker u_adc_checker (.clk, .rst_n, .m_axis_tvalid,
    .m_axis_tready, .m_axis_tdata, .m_axis_tlast);
`default_nettype wire
